### hdl/assert_macros.svh
// Assertion macros shared by the segmenter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/gips_pkg.sv
// Shared constants, types and register codes of the green index palette segmenter.
`default_nettype none

package gips_pkg;

  // Palette geometry
  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
  // Index compare width, wide enough for palette depths up to 4096
  localparam int IDX_W         = 13;

  // Datapath widths
  localparam int COMP_W  = 8;
  localparam int BIN_W   = 10;
  localparam int NUM_W   = 18;
  localparam int DEN_W   = 10;
  localparam int REM_W   = NUM_W + 1;
  localparam int COLOR_W = 24;
  localparam int ENTRY_W = 8;

  // Divider: one quotient bit per stage
  localparam int DIV_STAGES = BIN_W;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [COMP_W-1:0] FULL_COMPONENT = 8'd255;

  // Register reset values
  localparam logic [9:0]  GRAIN_RST       = 10'd100;
  localparam logic [9:0]  LOW_BIN_RST     = 10'd0;
  localparam logic [10:0] HIGH_BIN_RST    = 11'd256;
  localparam logic        MASK_ENABLE_RST = 1'b0;

  typedef enum logic [1:0] {
    REG_GRAIN,
    REG_LOW_BIN,
    REG_HIGH_BIN,
    REG_MASK_ENABLE
  } reg_idx_t;

  typedef struct packed {
    logic [9:0]  grain;
    logic [9:0]  low_bin;
    logic [10:0] high_bin;
    logic        mask_enable;
  } cfg_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic               write;
    logic               black;
    logic [NUM_W-1:0]   numer;
    logic [DEN_W-1:0]   denom;
    logic [ENTRY_W-1:0] entry_index;
    logic [COLOR_W-1:0] entry_color;
  } queue_item_t;

  typedef struct packed {
    logic              head_valid;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  // One divider stage's contents
  typedef struct packed {
    logic               write;
    logic               black;
    logic [NUM_W-1:0]   rem;
    logic [BIN_W-1:0]   quo;
    logic [DEN_W-1:0]   denom;
    logic [ENTRY_W-1:0] entry_index;
    logic [COLOR_W-1:0] entry_color;
  } div_t;

endpackage

`default_nettype wire

### hdl/green_index_palette_segmenter.sv
// An accepted pixel request passes through the queue, the divider pipeline and the output register.
// Throughput: one request per cycle while the back end is not stalled; the ten-stage divider
// pipeline, one quotient bit per stage, and the single palette read port set that figure.
// out_ready low stalls the back end; a four-entry queue keeps taking requests until full.
// Reset clears the queue, pipeline valids and output valid, and loads register reset
// values; palette entries are undefined until written.
`default_nettype none

`include "assert_macros.svh"

module green_index_palette_segmenter
  import gips_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Request channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [COMP_W-1:0]  red,
  input  wire logic [COMP_W-1:0]  green,
  input  wire logic [COMP_W-1:0]  blue,
  input  wire logic [COMP_W-1:0]  mask_red,
  input  wire logic [COMP_W-1:0]  mask_green,
  input  wire logic [COMP_W-1:0]  mask_blue,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [COLOR_W-1:0] entry_color,
  // Result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [COMP_W-1:0]  out_red,
  output logic      [COMP_W-1:0]  out_green,
  output logic      [COMP_W-1:0]  out_blue,
  output logic      [BIN_W-1:0]   bin,
  output logic                    colored
);

  cfg_t              cfg;
  reg_idx_t          reg_idx;
  logic              cfg_wr;
  queue_item_t       front_item;
  queue_item_t       head;
  q_stat_t           q_stat;
  logic              push;
  logic              pop;
  logic [QCNT_W-1:0] count_step;
  logic              out_black;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grain       <= GRAIN_RST;
      cfg.low_bin     <= LOW_BIN_RST;
      cfg.high_bin    <= HIGH_BIN_RST;
      cfg.mask_enable <= MASK_ENABLE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRAIN:       cfg.grain       <= pwdata[9:0];
        REG_LOW_BIN:     cfg.low_bin     <= pwdata[9:0];
        REG_HIGH_BIN:    cfg.high_bin    <= pwdata[10:0];
        REG_MASK_ENABLE: cfg.mask_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (reg_idx)
      REG_GRAIN:       prdata = 32'(cfg.grain);
      REG_LOW_BIN:     prdata = 32'(cfg.low_bin);
      REG_HIGH_BIN:    prdata = 32'(cfg.high_bin);
      REG_MASK_ENABLE: prdata = 32'(cfg.mask_enable);
      default:         prdata = '0;
    endcase
  end

  // Accept a request whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  gips_front u_front (
    .kind       (kind),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .mask_red   (mask_red),
    .mask_green (mask_green),
    .mask_blue  (mask_blue),
    .entry_index(entry_index),
    .entry_color(entry_color),
    .cfg        (cfg),
    .item       (front_item)
  );

  gips_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(front_item),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  gips_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .head_valid(q_stat.head_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .bin       (bin),
    .colored   (colored)
  );

  // Expected queue occupancy after this cycle, and a black output pixel
  assign count_step = q_stat.count + QCNT_W'(push) - QCNT_W'(pop);
  assign out_black  = (out_red == '0) && (out_green == '0) && (out_blue == '0);

  // The back end pops only a queued request
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst, pop, q_stat.head_valid, "pop from empty queue")

  // Queue occupancy follows pushes and pops
  `ASSERT_NEXT(a_count_track, clk, rst, 1'b1, q_stat.count == $past(count_step), "bad queue count")

  // A result that did not use the palette is black
  `ASSERT_IMPLY(a_black_uncolored, clk, rst, out_valid && !colored, out_black, "result not black")

endmodule

`default_nettype wire

### hdl/gips_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module gips_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/gips_front.sv
// Front end: classify a request and form the division operands.
`default_nettype none

module gips_front
  import gips_pkg::*;
(
  input  wire logic               kind,
  input  wire logic [COMP_W-1:0]  red,
  input  wire logic [COMP_W-1:0]  green,
  input  wire logic [COMP_W-1:0]  blue,
  input  wire logic [COMP_W-1:0]  mask_red,
  input  wire logic [COMP_W-1:0]  mask_green,
  input  wire logic [COMP_W-1:0]  mask_blue,
  input  wire logic [ENTRY_W-1:0] entry_index,
  input  wire logic [COLOR_W-1:0] entry_color,
  input  wire cfg_t               cfg,
  output queue_item_t             item
);

  logic             mask_white;
  logic             masked;
  logic [DEN_W-1:0] sum;

  // With masking enabled, drop the pixel to black unless the mask pixel is pure white
  assign mask_white = (mask_red == FULL_COMPONENT) && (mask_green == FULL_COMPONENT) &&
                      (mask_blue == FULL_COMPONENT);
  assign masked     = cfg.mask_enable && !mask_white;

  assign sum = DEN_W'(red) + DEN_W'(green) + DEN_W'(blue);

  // Build the queued request; the product is registered by the queue
  assign item.write       = kind;
  assign item.black       = masked || (sum == '0);
  assign item.numer       = NUM_W'(green) * NUM_W'(cfg.grain);
  assign item.denom       = sum;
  assign item.entry_index = entry_index;
  assign item.entry_color = entry_color;

endmodule

`default_nettype wire

### hdl/gips_queue.sv
// Short queue between the front end and the back end.
`default_nettype none

module gips_queue
  import gips_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire queue_item_t push_item,
  input  wire logic        pop,
  output queue_item_t      head,
  output q_stat_t          stat
);

  queue_item_t       slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

  // Advance pointers; depth is a power of two so they wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head            = slots[rptr];
  assign stat.head_valid = (count != '0);
  assign stat.full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.count      = count;

endmodule

`default_nettype wire

### hdl/gips_back.sv
// Back end: pipelined bin division, palette lookup and write, output register.
`default_nettype none

module gips_back
  import gips_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire queue_item_t        head,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COMP_W-1:0]       out_red,
  output logic [COMP_W-1:0]       out_green,
  output logic [COMP_W-1:0]       out_blue,
  output logic [BIN_W-1:0]        bin,
  output logic                    colored
);

  logic                  adv;
  logic [DIV_STAGES-1:0] stage_valid;
  div_t                  stage      [DIV_STAGES];
  div_t                  stage_next [DIV_STAGES];

  // Advance the whole back end unless a result is waiting to be taken
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  // One restoring-division step per stage, most significant quotient bit first
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int SH = BIN_W - 1 - k;
    div_t             src;
    logic [REM_W-1:0] dsh;
    logic             ge;
    logic [NUM_W-1:0] rem_sub;

    if (k == 0) begin : g_first
      assign src = '{write: head.write, black: head.black, rem: head.numer, quo: '0,
                     denom: head.denom, entry_index: head.entry_index,
                     entry_color: head.entry_color};
    end else begin : g_rest
      assign src = stage[k-1];
    end

    assign dsh     = REM_W'(src.denom) << SH;
    assign ge      = {1'b0, src.rem} >= dsh;
    assign rem_sub = NUM_W'({1'b0, src.rem} - dsh);

    assign stage_next[k] = '{write: src.write, black: src.black,
                             rem: ge ? rem_sub : src.rem,
                             quo: ge ? (src.quo | (BIN_W'(1) << SH)) : src.quo,
                             denom: src.denom, entry_index: src.entry_index,
                             entry_color: src.entry_color};
  end

  // Shift valid flags through the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (adv) begin
      stage_valid <= {stage_valid[DIV_STAGES-2:0], pop};
    end
  end

  // Shift divider payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stage[k] <= stage_next[k];
      end
    end
  end

  // Classify the finished bin and form palette addresses
  div_t               last;
  logic               last_valid;
  logic               in_range;
  logic [BIN_W-1:0]   idx;
  logic [IDX_W-1:0]   idx_wide;
  logic               idx_ok;
  logic               hit;
  logic [IDX_W-1:0]   ent_wide;
  logic               ent_ok;
  logic               pal_we;
  logic [PAL_AW-1:0]  pal_raddr;
  logic [PAL_AW-1:0]  pal_waddr;
  logic [COLOR_W-1:0] pal_rdata;

  assign last       = stage[DIV_STAGES-1];
  assign last_valid = stage_valid[DIV_STAGES-1];

  assign in_range = (last.quo >= cfg.low_bin) && ({1'b0, last.quo} < cfg.high_bin);
  assign idx      = last.quo - cfg.low_bin;
  assign idx_wide = IDX_W'(idx);
  assign idx_ok   = idx_wide < IDX_W'(PALETTE_DEPTH);
  assign hit      = !last.black && in_range && idx_ok;

  assign ent_wide  = IDX_W'(last.entry_index);
  assign ent_ok    = ent_wide < IDX_W'(PALETTE_DEPTH);
  assign pal_we    = adv && last_valid && last.write && ent_ok;
  assign pal_raddr = idx_wide[PAL_AW-1:0];
  assign pal_waddr = ent_wide[PAL_AW-1:0];

  // Palette store; a write is seen by any later request's read
  gips_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(pal_waddr),
    .wdata(last.entry_color),
    .re   (adv),
    .raddr(pal_raddr),
    .rdata(pal_rdata)
  );

  // Output register; palette writes leave no result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= last_valid && !last.write;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bin     <= last.black ? '0 : last.quo;
      colored <= hit;
    end
  end

  // Black unless the palette color was used
  assign out_red   = colored ? pal_rdata[23:16] : '0;
  assign out_green = colored ? pal_rdata[15:8]  : '0;
  assign out_blue  = colored ? pal_rdata[7:0]   : '0;

endmodule

`default_nettype wire
